// File: hdl/escc_pkg.sv
// escc_pkg: types, constants and small table functions for the epoch seconds
// calendar converter. No dependencies; used by epoch_seconds_calendar_converter.
package escc_pkg;

  // input item, one transfer on the input channel
  typedef struct packed {
    logic        op;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic [31:0] seconds_in;
  } in_item_t;

  // result item, one transfer on the output channel
  typedef struct packed {
    logic [31:0] seconds_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
  } out_item_t;

  // operation codes
  localparam logic OP_CAL_TO_SEC = 1'b0;
  localparam logic OP_SEC_TO_CAL = 1'b1;

  // epoch and its position in the leap cycles (1990 mod 4, 100, 400)
  localparam logic [11:0] EPOCH_YEAR    = 12'd1990;
  localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100  = 7'd90;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd390;
  localparam logic [6:0]  LAST_MOD100   = 7'd99;
  localparam logic [8:0]  LAST_MOD400   = 9'd399;
  // weekday of day 0 (1 Jan 1990, a Monday)
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd1;

  localparam logic [31:0] SEC_PER_MIN        = 32'd60;
  localparam logic [31:0] SEC_PER_HOUR       = 32'd3600;
  localparam logic [31:0] SEC_PER_DAY        = 32'd86400;
  // minus one day, modulo 2^32
  localparam logic [31:0] NEG_SEC_PER_DAY    = 32'hFFFE_AE80;
  localparam logic [31:0] SEC_PER_YEAR       = 32'd31536000;
  localparam logic [31:0] SEC_PER_LEAP_YEAR  = 32'd31622400;

  localparam logic [3:0]  LAST_MONTH_IDX  = 4'd11;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [4:0]  MIN_MONTH_LEN   = 5'd28;

  // length of a month, index 0 = January
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
    case (idx)
      4'd1:                   return leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  // seconds in a month
  function automatic logic [31:0] month_secs(input logic leap, input logic [3:0] idx);
    case (month_len(leap, idx))
      5'd28:   return 32'd2419200;
      5'd29:   return 32'd2505600;
      5'd30:   return 32'd2592000;
      default: return 32'd2678400;
    endcase
  endfunction

  // weekday step of a month: its length mod 7
  function automatic logic [2:0] month_wd_step(input logic leap, input logic [3:0] idx);
    logic [4:0] len;
    len = month_len(leap, idx) - MIN_MONTH_LEN;
    return len[2:0];
  endfunction

  // weekday plus a small step, mod 7
  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] step);
    logic [3:0] s;
    s = {1'b0, wd} + {1'b0, step};
    if (s >= 4'd7) s = s - 4'd7;
    return s[2:0];
  endfunction

endpackage

// File: hdl/escc_chan_if.sv
// escc_chan_if: valid/ready channel carrying one payload struct per transfer.
// The payload type is set by the instantiating level (escc_pkg structs).
interface escc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/escc_addsub.sv
// escc_addsub: the shared 32-bit add / subtract-compare unit of the converter.
// Depends on nothing; instantiated once by epoch_seconds_calendar_converter.
module escc_addsub (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] sum_o,
  output logic        carry_o
);

  logic [32:0] full;

  // a + b, or a - b with carry set when a >= b
  assign full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {32'd0, sub_i};
  assign sum_o   = full[31:0];
  assign carry_o = full[32];

endmodule

// File: hdl/epoch_seconds_calendar_converter.sv
// Epoch seconds calendar converter. With op = 0 an item carrying year, month,
// day, hour, minute and second gives the count of seconds since 1990-01-01
// 00:00:00, modulo 2^32 (for a year before 1990, the seconds since the start
// of that year); with op = 1 an item carrying a seconds count gives year,
// month, day, hour, minute, second and weekday (0 = Sunday). Gregorian leap
// rules. All seconds arithmetic runs through one shared 32-bit adder stepped
// by a small sequencer, so the block takes one item at a time: ready is high
// only while the sequencer is idle. Calendar to seconds adds whole years,
// months, days, hours and minutes and then the seconds to the count; for
// years before 1990 the year walk starts at year 0 and adds nothing. Seconds
// to calendar strips whole years, months, days, hours and minutes off the
// count by compare and subtract. A finished result waits in the output
// register; the sequencer turns idle as it parks it there, so the next item
// can be taken while the result still waits.
// Depends on escc_pkg, escc_chan_if and escc_addsub.
module epoch_seconds_calendar_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  escc_chan_if.sink         in_ch_i,
  escc_chan_if.source       out_ch_o
);
  import escc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_YEAR_ADD,
    S_MONTH_ADD,
    S_DAY_ADD,
    S_HOUR_ADD,
    S_MIN_ADD,
    S_SEC_ADD,
    S_YEAR_SUB,
    S_MONTH_SUB,
    S_DAY_SUB,
    S_HOUR_SUB,
    S_MIN_SUB,
    S_DONE
  } state_e;

  state_e      state_q;
  in_item_t    in_q;
  out_item_t   out_q;
  logic        out_valid_q;
  logic [31:0] acc_q;
  logic [11:0] yr_q;
  logic [1:0]  m4_q;
  logic [6:0]  m100_q;
  logic [8:0]  m400_q;
  logic [3:0]  mo_q;
  logic [5:0]  cnt_q;
  logic [2:0]  wd_q;
  logic [4:0]  day_q;
  logic [4:0]  hr_q;
  logic [5:0]  mi_q;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic [31:0] alu_sum;
  logic        alu_carry;

  logic        leap;
  logic [6:0]  m100_nx;
  logic [8:0]  m400_nx;
  logic [3:0]  whole_months;
  logic        out_free;
  logic        park_result;
  out_item_t   res_d;
  in_item_t    in_item;

  assign in_item = in_ch_i.payload;

  // leap flag of the year under the year counter
  assign leap    = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign m100_nx = (m100_q == LAST_MOD100) ? 7'd0 : m100_q + 7'd1;
  assign m400_nx = (m400_q == LAST_MOD400) ? 9'd0 : m400_q + 9'd1;

  // whole months before the given one, clamped to a year
  always_comb begin
    if (in_q.month_in == 4'd0) begin
      whole_months = 4'd0;
    end else if (in_q.month_in > MONTHS_PER_YEAR) begin
      whole_months = MONTHS_PER_YEAR;
    end else begin
      whole_months = in_q.month_in - 4'd1;
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a   = acc_q;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    case (state_q)
      S_YEAR_ADD:  alu_b = leap ? SEC_PER_LEAP_YEAR : SEC_PER_YEAR;
      S_MONTH_ADD: alu_b = month_secs(leap, mo_q);
      S_DAY_ADD:   alu_b = (cnt_q == 6'd0) ? NEG_SEC_PER_DAY : SEC_PER_DAY;
      S_HOUR_ADD:  alu_b = SEC_PER_HOUR;
      S_MIN_ADD:   alu_b = SEC_PER_MIN;
      S_SEC_ADD:   alu_b = {26'd0, in_q.second_in};
      S_YEAR_SUB: begin
        alu_b   = leap ? SEC_PER_LEAP_YEAR : SEC_PER_YEAR;
        alu_sub = 1'b1;
      end
      S_MONTH_SUB: begin
        alu_b   = month_secs(leap, mo_q);
        alu_sub = 1'b1;
      end
      S_DAY_SUB: begin
        alu_b   = SEC_PER_DAY;
        alu_sub = 1'b1;
      end
      S_HOUR_SUB: begin
        alu_b   = SEC_PER_HOUR;
        alu_sub = 1'b1;
      end
      S_MIN_SUB: begin
        alu_b   = SEC_PER_MIN;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  escc_addsub u_addsub (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // result item as it will be parked
  always_comb begin
    res_d = '0;
    if (in_q.op == OP_SEC_TO_CAL) begin
      res_d.year_out    = yr_q;
      res_d.month_out   = mo_q + 4'd1;
      res_d.day_out     = day_q + 5'd1;
      res_d.hour_out    = hr_q;
      res_d.minute_out  = mi_q;
      res_d.second_out  = acc_q[5:0];
      res_d.weekday_out = wd_q;
    end else begin
      res_d.seconds_out = acc_q;
    end
  end

  assign out_free    = !out_valid_q || out_ch_o.ready;
  assign park_result = (state_q == S_DONE) && out_free;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      in_q        <= '0;
      out_q       <= '0;
      acc_q       <= '0;
      yr_q        <= '0;
      m4_q        <= '0;
      m100_q      <= '0;
      m400_q      <= '0;
      mo_q        <= '0;
      cnt_q       <= '0;
      wd_q        <= '0;
      day_q       <= '0;
      hr_q        <= '0;
      mi_q        <= '0;
    end else begin
      // park a finished result, or drop the one taken downstream
      if (park_result) begin
        out_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_ch_i.valid) begin
            in_q  <= in_item;
            mo_q  <= 4'd0;
            if (in_item.op == OP_SEC_TO_CAL) begin
              acc_q   <= in_item.seconds_in;
              yr_q    <= EPOCH_YEAR;
              m4_q    <= EPOCH_MOD4;
              m100_q  <= EPOCH_MOD100;
              m400_q  <= EPOCH_MOD400;
              wd_q    <= EPOCH_WEEKDAY;
              day_q   <= 5'd0;
              hr_q    <= 5'd0;
              mi_q    <= 6'd0;
              state_q <= S_YEAR_SUB;
            end else begin
              acc_q <= 32'd0;
              // years before the epoch only need the leap flag of the year
              if (in_item.year_in >= EPOCH_YEAR) begin
                yr_q   <= EPOCH_YEAR;
                m4_q   <= EPOCH_MOD4;
                m100_q <= EPOCH_MOD100;
                m400_q <= EPOCH_MOD400;
              end else begin
                yr_q   <= 12'd0;
                m4_q   <= 2'd0;
                m100_q <= 7'd0;
                m400_q <= 9'd0;
              end
              state_q <= S_YEAR_ADD;
            end
          end
        end

        // calendar to seconds: whole years
        S_YEAR_ADD: begin
          if (yr_q != in_q.year_in) begin
            if (yr_q >= EPOCH_YEAR) acc_q <= alu_sum;
            yr_q   <= yr_q + 12'd1;
            m4_q   <= m4_q + 2'd1;
            m100_q <= m100_nx;
            m400_q <= m400_nx;
          end else begin
            state_q <= S_MONTH_ADD;
          end
        end

        // whole months of the current year
        S_MONTH_ADD: begin
          if (mo_q < whole_months) begin
            acc_q <= alu_sum;
            mo_q  <= mo_q + 4'd1;
          end else begin
            cnt_q   <= {1'b0, in_q.day_in};
            state_q <= S_DAY_ADD;
          end
        end

        // whole days; day zero steps back one day
        S_DAY_ADD: begin
          if (cnt_q == 6'd0) begin
            acc_q   <= alu_sum;
            cnt_q   <= {1'b0, in_q.hour_in};
            state_q <= S_HOUR_ADD;
          end else if (cnt_q == 6'd1) begin
            cnt_q   <= {1'b0, in_q.hour_in};
            state_q <= S_HOUR_ADD;
          end else begin
            acc_q <= alu_sum;
            cnt_q <= cnt_q - 6'd1;
          end
        end

        S_HOUR_ADD: begin
          if (cnt_q != 6'd0) begin
            acc_q <= alu_sum;
            cnt_q <= cnt_q - 6'd1;
          end else begin
            cnt_q   <= in_q.minute_in;
            state_q <= S_MIN_ADD;
          end
        end

        S_MIN_ADD: begin
          if (cnt_q != 6'd0) begin
            acc_q <= alu_sum;
            cnt_q <= cnt_q - 6'd1;
          end else begin
            state_q <= S_SEC_ADD;
          end
        end

        S_SEC_ADD: begin
          acc_q   <= alu_sum;
          state_q <= S_DONE;
        end

        // seconds to calendar: whole years off the count
        S_YEAR_SUB: begin
          if (alu_carry) begin
            acc_q  <= alu_sum;
            yr_q   <= yr_q + 12'd1;
            m4_q   <= m4_q + 2'd1;
            m100_q <= m100_nx;
            m400_q <= m400_nx;
            wd_q   <= wd_add(wd_q, leap ? 3'd2 : 3'd1);
          end else begin
            state_q <= S_MONTH_SUB;
          end
        end

        // whole months off the count, December takes the rest
        S_MONTH_SUB: begin
          if ((mo_q < LAST_MONTH_IDX) && alu_carry) begin
            acc_q <= alu_sum;
            mo_q  <= mo_q + 4'd1;
            wd_q  <= wd_add(wd_q, month_wd_step(leap, mo_q));
          end else begin
            state_q <= S_DAY_SUB;
          end
        end

        // whole days off the count
        S_DAY_SUB: begin
          if (alu_carry) begin
            acc_q <= alu_sum;
            day_q <= day_q + 5'd1;
            wd_q  <= wd_add(wd_q, 3'd1);
          end else begin
            state_q <= S_HOUR_SUB;
          end
        end

        S_HOUR_SUB: begin
          if (alu_carry) begin
            acc_q <= alu_sum;
            hr_q  <= hr_q + 5'd1;
          end else begin
            state_q <= S_MIN_SUB;
          end
        end

        S_MIN_SUB: begin
          if (alu_carry) begin
            acc_q <= alu_sum;
            mi_q  <= mi_q + 6'd1;
          end else begin
            state_q <= S_DONE;
          end
        end

        // wait until the output register is free
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch_i.ready    = (state_q == S_IDLE);
  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.payload = out_q;

endmodule
